// ===== hdl/cfp_pkg.sv =====
// Shared types and constants for the class file structure parser.
`default_nettype none
package cfp_pkg;

  localparam logic [31:0] MAGIC_WORD = 32'hCAFEBABE;

  typedef enum logic [4:0] {
    PH_MAGIC, PH_MINOR, PH_MAJOR, PH_PCOUNT, PH_PTAG, PH_UTFLEN, PH_PSKIP,
    PH_ACCESS, PH_THIS, PH_SUPER, PH_IFCOUNT, PH_IFACE, PH_MCOUNT, PH_MACC,
    PH_MNAME, PH_MDESC, PH_ACOUNT, PH_ANAME, PH_ALEN, PH_ASKIP, PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    K_MAGIC, K_MINOR, K_MAJOR, K_PCOUNT, K_PENTRY, K_ACCESS, K_THIS, K_SUPER,
    K_IFCOUNT, K_IFACE, K_MCOUNT, K_MACC, K_MNAME, K_MDESC, K_ACOUNT, K_AHDR
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK, ST_TRUNC, ST_MAGIC, ST_ZPOOL, ST_TAG, ST_WIDE, ST_TRAIL
  } status_t;

  localparam logic [7:0] TAG_UTF8   = 8'd1;
  localparam logic [7:0] TAG_LONG   = 8'd5;
  localparam logic [7:0] TAG_DOUBLE = 8'd6;
  localparam logic [7:0] TAG_MAX    = 8'd12;

  typedef struct packed {
    logic [1:0]  section;
    logic [3:0]  record_kind;
    logic [31:0] field_value;
    logic [15:0] aux_value;
    logic [15:0] entry_index;
    logic [15:0] attr_index;
    logic [31:0] byte_offset;
    logic        is_final;
    logic [2:0]  status;
  } result_t;

  // Info length of a constant pool entry by tag
  function automatic logic [3:0] info_len(input logic [3:0] tag);
    case (tag)
      4'd3, 4'd4, 4'd9, 4'd10, 4'd11, 4'd12: info_len = 4'd4;
      4'd5, 4'd6:                            info_len = 4'd8;
      4'd7, 4'd8:                            info_len = 4'd2;
      default:                               info_len = 4'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cfp_byte_if.sv =====
// Input channel: one class file byte with a last flag.
`default_nettype none
interface cfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface
`default_nettype wire

// ===== hdl/cfp_rec_if.sv =====
// Output channel: one parser record or closing status.
`default_nettype none
interface cfp_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  section;
  logic [3:0]  record_kind;
  logic [31:0] field_value;
  logic [15:0] aux_value;
  logic [15:0] entry_index;
  logic [15:0] attr_index;
  logic [31:0] byte_offset;
  logic        is_final;
  logic [2:0]  status;
  modport source (output valid, section, record_kind, field_value, aux_value,
                  entry_index, attr_index, byte_offset, is_final, status,
                  input ready);
  modport sink   (input valid, section, record_kind, field_value, aux_value,
                  entry_index, attr_index, byte_offset, is_final, status,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/class_file_structure_parser.sv =====
// Top level of the class file structure parser.
// A record or closing status is written into the result queue and reaches the output after any entries ahead of it.
// Throughput: one byte per cycle while the four-entry result queue has room for two.
// A byte that yields a record and a closing status queues both, the record ahead of the status.
// Reset (rst, synchronous) empties the queue and returns the parser to the magic word;
// the final byte of each file also re-arms the parser.
`default_nettype none
module class_file_structure_parser
  import cfp_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input wire logic clk,
  input wire logic rst,
  cfp_byte_if.sink  in_ch,
  cfp_rec_if.source out_ch
);

  logic    take, rec_valid, fin_valid, room;
  result_t rec, fin, q_data;

  assign in_ch.ready = room;
  assign take        = in_ch.valid && room;

  cfp_walker #(.OFFSET_BITS(OFFSET_BITS)) u_walker (
    .clk, .rst, .take,
    .data_byte(in_ch.data_byte),
    .last_byte(in_ch.last_byte),
    .rec_valid, .rec, .fin_valid, .fin
  );

  cfp_out_queue u_queue (
    .clk, .rst,
    .push_a(take && rec_valid), .data_a(rec),
    .push_b(take && fin_valid), .data_b(fin),
    .room,
    .out_valid(out_ch.valid), .out_data(q_data), .out_ready(out_ch.ready)
  );

  assign out_ch.section     = q_data.section;
  assign out_ch.record_kind = q_data.record_kind;
  assign out_ch.field_value = q_data.field_value;
  assign out_ch.aux_value   = q_data.aux_value;
  assign out_ch.entry_index = q_data.entry_index;
  assign out_ch.attr_index  = q_data.attr_index;
  assign out_ch.byte_offset = q_data.byte_offset;
  assign out_ch.is_final    = q_data.is_final;
  assign out_ch.status      = q_data.status;

endmodule
`default_nettype wire

// ===== hdl/cfp_walker.sv =====
// Parse state and per-byte decode; produces up to two results per byte.
`default_nettype none
module cfp_walker
  import cfp_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            rec_valid,
  output result_t         rec,
  output logic            fin_valid,
  output result_t         fin
);

  phase_t                 parse_phase, parse_phase_next;
  logic [1:0]             field_byte_count, field_byte_count_next;
  logic [31:0]            field_accum, field_accum_next;
  logic [OFFSET_BITS-1:0] field_start, field_start_next;
  logic [OFFSET_BITS-1:0] file_offset;
  logic [15:0]            pool_total, pool_total_next;
  logic [15:0]            pool_slot, pool_slot_next;
  logic [15:0]            list_total, list_total_next;
  logic [15:0]            list_slot, list_slot_next;
  logic [15:0]            attr_total, attr_total_next;
  logic [15:0]            attr_slot, attr_slot_next;
  logic [15:0]            attr_name_hold, attr_name_hold_next;
  logic [31:0]            skip_left, skip_left_next;
  logic [2:0]             error_code, error_code_next;
  logic [1:0]             section_sel, section_sel_next;

  logic [OFFSET_BITS-1:0] nxt_off, st_off;
  logic [31:0]            v;
  logic [1:0]             width_m1;
  logic [15:0]            v16, list_inc, attr_inc, owner_idx;
  logic [7:0]             tag;
  logic                   emit;
  kind_t                  ekind;
  logic [31:0]            evalue;
  logic [15:0]            eaux, eentry, eattr;
  logic [OFFSET_BITS-1:0] eoff;

  assign nxt_off = file_offset + OFFSET_BITS'(1);

  always_comb begin
    parse_phase_next      = parse_phase;
    field_byte_count_next = field_byte_count;
    field_accum_next      = field_accum;
    field_start_next      = field_start;
    pool_total_next       = pool_total;
    pool_slot_next        = pool_slot;
    list_total_next       = list_total;
    list_slot_next        = list_slot;
    attr_total_next       = attr_total;
    attr_slot_next        = attr_slot;
    attr_name_hold_next   = attr_name_hold;
    skip_left_next        = skip_left;
    error_code_next       = error_code;
    section_sel_next      = section_sel;
    emit   = 1'b0;
    ekind  = K_MAGIC;
    evalue = '0;
    eaux   = '0;
    eentry = '0;
    eattr  = '0;
    st_off = (field_byte_count == 2'd0) ? file_offset : field_start;
    eoff   = st_off;
    v      = {(field_byte_count == 2'd0) ? 24'd0 : field_accum[23:0], data_byte};
    v16    = v[15:0];
    tag    = data_byte;
    list_inc  = list_slot + 16'd1;
    attr_inc  = attr_slot + 16'd1;
    owner_idx = (section_sel == 2'd3) ? 16'd0 : list_slot;
    width_m1  = (parse_phase == PH_MAGIC || parse_phase == PH_ALEN) ? 2'd3
              : (parse_phase == PH_PTAG) ? 2'd0 : 2'd1;

    if (error_code == ST_OK) begin
      if (parse_phase == PH_DONE) begin
        error_code_next = ST_TRAIL;
      end else if (parse_phase == PH_PSKIP || parse_phase == PH_ASKIP) begin
        // count down payload bytes
        skip_left_next = skip_left - 32'd1;
        if (skip_left == 32'd1) begin
          if (parse_phase == PH_PSKIP) begin
            parse_phase_next = (pool_slot >= pool_total) ? PH_ACCESS : PH_PTAG;
          end else begin
            attr_slot_next = attr_inc;
            if (attr_inc < attr_total) parse_phase_next = PH_ANAME;
            else if (section_sel == 2'd3) parse_phase_next = PH_DONE;
            else begin
              list_slot_next = list_inc;
              if (list_inc < list_total) parse_phase_next = PH_MACC;
              else if (section_sel == 2'd1) begin
                section_sel_next = 2'd2; parse_phase_next = PH_MCOUNT;
              end else begin
                section_sel_next = 2'd3; parse_phase_next = PH_ACOUNT;
              end
            end
          end
        end
      end else begin
        field_start_next = st_off;
        field_accum_next = v;
        if (field_byte_count != width_m1) begin
          field_byte_count_next = field_byte_count + 2'd1;
        end else begin
          field_byte_count_next = 2'd0;
          emit   = 1'b1;
          evalue = v;
          case (parse_phase)
            PH_MAGIC: begin
              ekind = K_MAGIC;
              if (v != MAGIC_WORD) begin
                emit = 1'b0; error_code_next = ST_MAGIC;
              end else parse_phase_next = PH_MINOR;
            end
            PH_MINOR: begin ekind = K_MINOR; parse_phase_next = PH_MAJOR; end
            PH_MAJOR: begin ekind = K_MAJOR; parse_phase_next = PH_PCOUNT; end
            PH_PCOUNT: begin
              ekind = K_PCOUNT;
              if (v16 == 16'd0) begin
                emit = 1'b0; error_code_next = ST_ZPOOL;
              end else begin
                pool_total_next  = v16;
                pool_slot_next   = 16'd1;
                parse_phase_next = (v16 <= 16'd1) ? PH_ACCESS : PH_PTAG;
              end
            end
            PH_PTAG: begin
              ekind  = K_PENTRY;
              eentry = pool_slot;
              eoff   = nxt_off;
              if (tag == 8'd0 || tag == 8'd2 || tag > TAG_MAX) begin
                emit = 1'b0; error_code_next = ST_TAG;
              end else if ((tag == TAG_LONG || tag == TAG_DOUBLE) &&
                           (pool_slot >= pool_total - 16'd1)) begin
                emit = 1'b0; error_code_next = ST_WIDE;
              end else begin
                pool_slot_next = pool_slot +
                  ((tag == TAG_LONG || tag == TAG_DOUBLE) ? 16'd2 : 16'd1);
                if (tag == TAG_UTF8) parse_phase_next = PH_UTFLEN;
                else begin
                  skip_left_next   = {28'd0, info_len(tag[3:0])};
                  parse_phase_next = PH_PSKIP;
                end
              end
            end
            PH_UTFLEN: begin
              emit = 1'b0;
              skip_left_next = v;
              if (v16 == 16'd0)
                parse_phase_next = (pool_slot >= pool_total) ? PH_ACCESS : PH_PTAG;
              else parse_phase_next = PH_PSKIP;
            end
            PH_ACCESS: begin ekind = K_ACCESS; parse_phase_next = PH_THIS; end
            PH_THIS:   begin ekind = K_THIS;   parse_phase_next = PH_SUPER; end
            PH_SUPER:  begin ekind = K_SUPER;  parse_phase_next = PH_IFCOUNT; end
            PH_IFCOUNT: begin
              ekind = K_IFCOUNT;
              list_total_next = v16;
              list_slot_next  = 16'd0;
              if (v16 == 16'd0) begin
                section_sel_next = 2'd1; parse_phase_next = PH_MCOUNT;
              end else parse_phase_next = PH_IFACE;
            end
            PH_IFACE: begin
              ekind  = K_IFACE;
              eentry = list_slot;
              list_slot_next = list_inc;
              if (list_inc >= list_total) begin
                section_sel_next = 2'd1; parse_phase_next = PH_MCOUNT;
              end
            end
            PH_MCOUNT: begin
              ekind = K_MCOUNT;
              list_total_next = v16;
              list_slot_next  = 16'd0;
              if (v16 != 16'd0) parse_phase_next = PH_MACC;
              else if (section_sel == 2'd1) begin
                section_sel_next = 2'd2; parse_phase_next = PH_MCOUNT;
              end else begin
                section_sel_next = 2'd3; parse_phase_next = PH_ACOUNT;
              end
            end
            PH_MACC:  begin ekind = K_MACC;  eentry = list_slot; parse_phase_next = PH_MNAME; end
            PH_MNAME: begin ekind = K_MNAME; eentry = list_slot; parse_phase_next = PH_MDESC; end
            PH_MDESC: begin ekind = K_MDESC; eentry = list_slot; parse_phase_next = PH_ACOUNT; end
            PH_ACOUNT: begin
              ekind  = K_ACOUNT;
              eentry = owner_idx;
              attr_total_next = v16;
              attr_slot_next  = 16'd0;
              if (v16 != 16'd0) parse_phase_next = PH_ANAME;
              else if (section_sel == 2'd3) parse_phase_next = PH_DONE;
              else begin
                list_slot_next = list_inc;
                if (list_inc < list_total) parse_phase_next = PH_MACC;
                else if (section_sel == 2'd1) begin
                  section_sel_next = 2'd2; parse_phase_next = PH_MCOUNT;
                end else begin
                  section_sel_next = 2'd3; parse_phase_next = PH_ACOUNT;
                end
              end
            end
            PH_ANAME: begin
              emit = 1'b0;
              attr_name_hold_next = v16;
              parse_phase_next    = PH_ALEN;
            end
            PH_ALEN: begin
              ekind  = K_AHDR;
              eaux   = attr_name_hold;
              eentry = owner_idx;
              eattr  = attr_slot;
              eoff   = nxt_off;
              skip_left_next = v;
              if (v != 32'd0) parse_phase_next = PH_ASKIP;
              else begin
                attr_slot_next = attr_inc;
                if (attr_inc < attr_total) parse_phase_next = PH_ANAME;
                else if (section_sel == 2'd3) parse_phase_next = PH_DONE;
                else begin
                  list_slot_next = list_inc;
                  if (list_inc < list_total) parse_phase_next = PH_MACC;
                  else if (section_sel == 2'd1) begin
                    section_sel_next = 2'd2; parse_phase_next = PH_MCOUNT;
                  end else begin
                    section_sel_next = 2'd3; parse_phase_next = PH_ACOUNT;
                  end
                end
              end
            end
            default: emit = 1'b0;
          endcase
        end
      end
    end
  end

  // Result records, combinational from current state and byte
  always_comb begin
    rec_valid       = emit;
    rec.section     = section_sel;
    rec.record_kind = ekind;
    rec.field_value = evalue;
    rec.aux_value   = eaux;
    rec.entry_index = eentry;
    rec.attr_index  = eattr;
    rec.byte_offset = 32'(eoff);
    rec.is_final    = 1'b0;
    rec.status      = ST_OK;
    fin_valid       = last_byte;
    fin             = '0;
    fin.is_final    = 1'b1;
    fin.status      = (error_code_next != ST_OK) ? error_code_next
                    : (parse_phase_next == PH_DONE) ? ST_OK : ST_TRUNC;
  end

  // Advance state on each accepted byte; re-arm after the last one
  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      parse_phase      <= PH_MAGIC;
      field_byte_count <= '0;
      field_accum      <= '0;
      field_start      <= '0;
      file_offset      <= '0;
      pool_total       <= '0;
      pool_slot        <= '0;
      list_total       <= '0;
      list_slot        <= '0;
      attr_total       <= '0;
      attr_slot        <= '0;
      attr_name_hold   <= '0;
      skip_left        <= '0;
      error_code       <= ST_OK;
      section_sel      <= '0;
    end else if (take) begin
      parse_phase      <= parse_phase_next;
      field_byte_count <= field_byte_count_next;
      field_accum      <= field_accum_next;
      field_start      <= field_start_next;
      file_offset      <= nxt_off;
      pool_total       <= pool_total_next;
      pool_slot        <= pool_slot_next;
      list_total       <= list_total_next;
      list_slot        <= list_slot_next;
      attr_total       <= attr_total_next;
      attr_slot        <= attr_slot_next;
      attr_name_hold   <= attr_name_hold_next;
      skip_left        <= skip_left_next;
      error_code       <= error_code_next;
      section_sel      <= section_sel_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cfp_out_queue.sv =====
// Four-entry result queue that lets two results per byte drain one per cycle while the output is ready.
`default_nettype none
module cfp_out_queue
  import cfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push_a,
  input  wire result_t data_a,
  input  wire logic    push_b,
  input  wire result_t data_b,
  output logic         room,
  output logic         out_valid,
  output result_t      out_data,
  input  wire logic    out_ready
);

  result_t    slots [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       pop;
  logic [1:0] n_push;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != 3'd0;
  assign out_data  = slots[rd_ptr];
  // space for two more even if nothing pops this cycle
  assign room      = count <= 3'd2;
  assign n_push    = {1'b0, push_a} + {1'b0, push_b};

  // Hold, write and advance the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_a) slots[wr_ptr] <= data_a;
      if (push_b) slots[push_a ? wr_ptr + 2'd1 : wr_ptr] <= data_b;
      wr_ptr <= wr_ptr + n_push;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, n_push} - {2'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cfp_checker.sv =====
// Port-level assertions for the class file structure parser, with bind.
`default_nettype none
module cfp_checker
  import cfp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_last,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_final,
  input wire logic [2:0] out_status,
  input wire logic [3:0] out_kind
);

  // Closing results carry a defined status
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_final |-> out_status <= ST_TRAIL)
    else $error("status code out of range");

  // Records carry status ok
  a_rec_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_final |-> out_status == ST_OK)
    else $error("record with nonzero status");

  // Closing result zeroes the kind
  a_final_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_final |-> out_kind == K_MAGIC)
    else $error("closing result has a kind");

  // A last byte is followed by output next cycle
  a_last_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> out_valid)
    else $error("no output after last byte");

  // Output stalled holds valid
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped");

endmodule

bind class_file_structure_parser cfp_checker u_cfp_checker (
  .clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.last_byte),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_final(out_ch.is_final), .out_status(out_ch.status),
  .out_kind(out_ch.record_kind)
);
`default_nettype wire
